FILE: hw/rtl/depth_tested_point_plotter_defines.svh
// assertion macros used by the checker file
`ifndef DEPTH_TESTED_POINT_PLOTTER_DEFINES_SVH
`define DEPTH_TESTED_POINT_PLOTTER_DEFINES_SVH

// clocked assertion, off while reset is held
`define DTPP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked during reset too
`define DTPP_ASSERT_RAW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/dtpp_pkg.sv
package dtpp_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int RAMP_LEN_DEF   = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DEPTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_DEPTH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_RAMP_MODE = 3'd4;

    localparam int SW_W        = 8;
    localparam int SH_W        = 7;
    localparam int COORD_W     = 16;
    localparam int DEPTH_W     = 15;
    localparam int INTEN_W     = 7;
    localparam int INTEN_SCALE = 100;
    localparam int DVD_W       = DEPTH_W + INTEN_W;
    localparam int QUO_W       = 7;
    localparam int STEP_W      = 3;
    localparam int SHADE_W     = 4;
    localparam int PIX_W       = 13;

    localparam logic OP_PLOT  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic load;
        logic check;
        logic mul_i;
        logic mul_n;
        logic div_step;
        logic sweep;
        logic decide;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_clear;
        logic pass;
        logic div_last;
        logic sweep_last;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/dtpp_in_if.sv
interface dtpp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 operation;
    logic signed [dtpp_pkg::COORD_W-1:0] point_x;
    logic signed [dtpp_pkg::COORD_W-1:0] point_y;
    logic signed [dtpp_pkg::COORD_W-1:0] point_z;

    modport source (output valid, operation, point_x, point_y, point_z, input ready);
    modport sink   (input valid, operation, point_x, point_y, point_z, output ready);
endinterface

FILE: hw/rtl/dtpp_out_if.sv
interface dtpp_out_if;
    logic                               valid;
    logic                               ready;
    logic                               pixel_written;
    logic [dtpp_pkg::PIX_W-1:0]        pixel_index;
    logic [dtpp_pkg::SHADE_W-1:0]      shade_index;
    logic [dtpp_pkg::INTEN_W-1:0]      pixel_intensity;

    modport source (output valid, pixel_written, pixel_index, shade_index, pixel_intensity,
                    input ready);
    modport sink   (input valid, pixel_written, pixel_index, shade_index, pixel_intensity,
                    output ready);
endinterface

FILE: hw/rtl/depth_tested_point_plotter.sv
// plot item: check and multiply, then straight to output if it fails the screen or depth test;
// else two 7-step serial divisions by far depth, the second after a ramp multiply, then decide
// clear item: sweeps the whole store, one entry per cycle, then goes to output
// one transaction at a time; the output register lets the next one enter while a result waits
// reset: synchronous active low, then a clearing pass over the whole store, input held off
module depth_tested_point_plotter #(
    parameter int MAX_WIDTH  = dtpp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtpp_pkg::MAX_HEIGHT_DEF,
    parameter int RAMP_LEN   = dtpp_pkg::RAMP_LEN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dtpp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dtpp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    dtpp_in_if.sink                            i_in,
    dtpp_out_if.source                         o_out
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [dtpp_pkg::SW_W-1:0]    r_screen_w;
    logic [dtpp_pkg::SH_W-1:0]    r_screen_h;
    logic [dtpp_pkg::DEPTH_W-1:0] r_near;
    logic [dtpp_pkg::DEPTH_W-1:0] r_far;
    logic                         r_full_ramp;

    logic [WW-1:0]  width_eff;
    logic [HW-1:0]  height_eff;
    dtpp_pkg::t_cmd cmd;
    dtpp_pkg::t_sts sts;
    logic           in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w  <= dtpp_pkg::SW_W'(80);
            r_screen_h  <= dtpp_pkg::SH_W'(40);
            r_near      <= dtpp_pkg::DEPTH_W'(1);
            r_far       <= dtpp_pkg::DEPTH_W'(100);
            r_full_ramp <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dtpp_pkg::CFG_SCREEN_WIDTH:   r_screen_w  <= i_cfg_data[dtpp_pkg::SW_W-1:0];
                dtpp_pkg::CFG_SCREEN_HEIGHT:  r_screen_h  <= i_cfg_data[dtpp_pkg::SH_W-1:0];
                dtpp_pkg::CFG_NEAR_DEPTH:     r_near      <= i_cfg_data;
                dtpp_pkg::CFG_FAR_DEPTH:      r_far       <= i_cfg_data;
                dtpp_pkg::CFG_FULL_RAMP_MODE: r_full_ramp <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // screen size clamped to the store
    always_comb begin
        if (int'(r_screen_w) < MAX_WIDTH) begin
            width_eff = WW'(r_screen_w);
        end else begin
            width_eff = WW'(MAX_WIDTH);
        end
        if (int'(r_screen_h) < MAX_HEIGHT) begin
            height_eff = HW'(r_screen_h);
        end else begin
            height_eff = HW'(MAX_HEIGHT);
        end
    end

    dtpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dtpp_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .RAMP_LEN   (RAMP_LEN),
        .WW         (WW),
        .HW         (HW)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_operation       (i_in.operation),
        .i_point_x         (i_in.point_x),
        .i_point_y         (i_in.point_y),
        .i_point_z         (i_in.point_z),
        .i_width           (width_eff),
        .i_height          (height_eff),
        .i_near            (r_near),
        .i_far             (r_far),
        .i_full_ramp       (r_full_ramp),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_pixel_written   (o_out.pixel_written),
        .o_pixel_index     (o_out.pixel_index),
        .o_shade_index     (o_out.shade_index),
        .o_pixel_intensity (o_out.pixel_intensity)
    );

    assign i_in.ready = in_ready;

endmodule

FILE: hw/rtl/dtpp_ctrl.sv
module dtpp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dtpp_pkg::t_sts i_sts,
    output dtpp_pkg::t_cmd o_cmd
);

    localparam logic [3:0] ST_SWEEP  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_CHECK  = 4'd2;
    localparam logic [3:0] ST_MUL_I  = 4'd3;
    localparam logic [3:0] ST_DIV_I  = 4'd4;
    localparam logic [3:0] ST_MUL_N  = 4'd5;
    localparam logic [3:0] ST_DIV_N  = 4'd6;
    localparam logic [3:0] ST_DECIDE = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_clr_item, n_clr_item;

    always_comb begin
        n_state    = r_state;
        n_clr_item = r_clr_item;
        o_cmd      = '0;
        o_in_ready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = r_clr_item ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_clear) begin
                        n_state    = ST_SWEEP;
                        n_clr_item = 1'b1;
                    end else begin
                        n_state    = ST_CHECK;
                        n_clr_item = 1'b0;
                    end
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = ST_MUL_I;
            end
            ST_MUL_I: begin
                o_cmd.mul_i = 1'b1;
                n_state     = i_sts.pass ? ST_DIV_I : ST_OUT;
            end
            ST_DIV_I: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_MUL_N;
                end
            end
            ST_MUL_N: begin
                o_cmd.mul_n = 1'b1;
                n_state     = ST_DIV_N;
            end
            ST_DIV_N: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_SWEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_SWEEP;
            r_clr_item <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_item <= n_clr_item;
        end
    end

endmodule

FILE: hw/rtl/dtpp_dp.sv
module dtpp_dp #(
    parameter int MAX_WIDTH  = dtpp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtpp_pkg::MAX_HEIGHT_DEF,
    parameter int RAMP_LEN   = dtpp_pkg::RAMP_LEN_DEF,
    parameter int WW         = $clog2(MAX_WIDTH + 1),
    parameter int HW         = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dtpp_pkg::t_cmd                   i_cmd,
    output dtpp_pkg::t_sts                   o_sts,
    input  logic                             i_operation,
    input  logic [dtpp_pkg::COORD_W-1:0]     i_point_x,
    input  logic [dtpp_pkg::COORD_W-1:0]     i_point_y,
    input  logic [dtpp_pkg::COORD_W-1:0]     i_point_z,
    input  logic [WW-1:0]                    i_width,
    input  logic [HW-1:0]                    i_height,
    input  logic [dtpp_pkg::DEPTH_W-1:0]     i_near,
    input  logic [dtpp_pkg::DEPTH_W-1:0]     i_far,
    input  logic                             i_full_ramp,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_pixel_written,
    output logic [dtpp_pkg::PIX_W-1:0]       o_pixel_index,
    output logic [dtpp_pkg::SHADE_W-1:0]     o_shade_index,
    output logic [dtpp_pkg::INTEN_W-1:0]     o_pixel_intensity
);

    localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
    localparam int PW    = WW + HW;
    localparam int NW    = $clog2(RAMP_LEN + 1);
    localparam int CW    = dtpp_pkg::COORD_W;
    localparam int DW    = dtpp_pkg::DEPTH_W;
    localparam int IW    = dtpp_pkg::INTEN_W;
    localparam int VW    = dtpp_pkg::DVD_W;
    localparam int QW    = dtpp_pkg::QUO_W;
    localparam int SW    = dtpp_pkg::STEP_W;
    localparam int HSW   = dtpp_pkg::SHADE_W;

    logic [IW-1:0] r_mem [STORE];

    logic [CW-1:0]  r_x, r_y, r_z;
    logic           r_pass;
    logic [AW-1:0]  r_pos;
    logic [DW-1:0]  r_diff;
    logic [VW-1:0]  r_dvd;
    logic [QW-1:0]  r_q;
    logic [SW-1:0]  r_step;
    logic [IW-1:0]  r_inten;
    logic [HSW-1:0] r_shade;
    logic           r_ok;
    logic [IW-1:0]  r_rd;
    logic [AW-1:0]  r_sw_addr;
    logic           r_out_valid;
    logic           r_out_wr;
    logic [dtpp_pkg::PIX_W-1:0] r_out_pix;
    logic [HSW-1:0] r_out_shade;
    logic [IW-1:0]  r_out_inten;

    logic           x_ok, y_ok, z_ok, pass;
    logic [PW-1:0]  prod;
    logic [NW-1:0]  ramp_n;
    logic [VW-1:0]  mul_b;
    logic [VW-1:0]  trial;
    logic           fits;
    logic [QW-1:0]  q_max;
    logic [QW-1:0]  q_cap;
    logic [HSW-1:0] shade;
    logic           visible;

    always_comb begin
        x_ok    = !r_x[CW-1] && (r_x < CW'(i_width));
        y_ok    = !r_y[CW-1] && (r_y < CW'(i_height));
        z_ok    = !r_z[CW-1] && (r_z >= CW'(i_near)) && (r_z <= CW'(i_far));
        pass    = (i_far != '0) && x_ok && y_ok && z_ok;
        prod    = PW'(r_y[HW-1:0]) * PW'(i_width) + PW'(r_x[WW-1:0]);
        ramp_n  = i_full_ramp ? NW'(RAMP_LEN) : NW'(2);
        mul_b   = i_cmd.mul_n ? VW'(ramp_n) : VW'(dtpp_pkg::INTEN_SCALE);
        trial   = VW'(i_far) << r_step;
        fits    = (r_dvd >= trial);
        q_max   = QW'(ramp_n) - QW'(1);
        q_cap   = (r_q > q_max) ? q_max : r_q;
        if (i_full_ramp) begin
            shade = HSW'(q_cap);
        end else begin
            shade = (q_cap != '0) ? HSW'(RAMP_LEN - 1) : '0;
        end
        visible = !(r_rd > r_inten);
    end

    assign o_sts.in_clear   = (i_operation == dtpp_pkg::OP_CLEAR);
    assign o_sts.pass       = r_pass;
    assign o_sts.div_last   = (r_step == '0);
    assign o_sts.sweep_last = (r_sw_addr == AW'(STORE - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // depth store
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            r_mem[r_sw_addr] <= '0;
        end else if (i_cmd.decide && visible) begin
            r_mem[r_pos] <= r_inten;
        end
        r_rd <= r_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_point_x;
            r_y <= i_point_y;
            r_z <= i_point_z;
        end
        if (i_cmd.check) begin
            r_pass <= pass;
            r_pos  <= prod[AW-1:0];
            r_diff <= i_far - r_z[DW-1:0];
        end
        if (i_cmd.mul_i || i_cmd.mul_n) begin
            r_dvd  <= VW'(r_diff) * mul_b;
            r_q    <= '0;
            r_step <= SW'(QW - 1);
        end else if (i_cmd.div_step) begin
            if (fits) begin
                r_dvd       <= r_dvd - trial;
                r_q[r_step] <= 1'b1;
            end
            r_step <= r_step - SW'(1);
        end
        if (i_cmd.mul_n) begin
            r_inten <= r_q;
        end
        if (i_cmd.load) begin
            r_ok <= 1'b0;
        end else if (i_cmd.decide) begin
            r_ok    <= visible;
            r_shade <= shade;
        end
        if (i_cmd.out_load) begin
            r_out_wr    <= r_ok;
            r_out_pix   <= r_ok ? dtpp_pkg::PIX_W'(r_pos) : '0;
            r_out_shade <= r_ok ? r_shade : '0;
            r_out_inten <= r_ok ? r_inten : '0;
        end
    end

    // sweep address and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_addr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_sw_addr <= '0;
            end else if (i_cmd.sweep) begin
                r_sw_addr <= r_sw_addr + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pixel_written   = r_out_wr;
    assign o_pixel_index     = r_out_pix;
    assign o_shade_index     = r_out_shade;
    assign o_pixel_intensity = r_out_inten;

endmodule

FILE: hw/rtl/dtpp_checker.sv
`include "depth_tested_point_plotter_defines.svh"

module dtpp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_pixel_written,
    input logic [dtpp_pkg::PIX_W-1:0]     i_pixel_index,
    input logic [dtpp_pkg::SHADE_W-1:0]   i_shade_index,
    input logic [dtpp_pkg::INTEN_W-1:0]   i_pixel_intensity
);

    // result holds until taken
    `DTPP_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "result dropped before taken")

    // a dropped point reports all-zero fields
    `DTPP_ASSERT_CLK(a_drop_zero, i_clk, i_rst_n, (i_out_valid && !i_pixel_written) |-> ((i_pixel_index == '0) && (i_shade_index == '0) && (i_pixel_intensity == '0)), "dropped point has nonzero fields")

    // one transaction in flight at a time
    `DTPP_ASSERT_CLK(a_one_item, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "input taken twice in a row")

    // clearing pass after reset keeps both sides quiet
    `DTPP_ASSERT_RAW(a_reset_quiet, i_clk, !i_rst_n |=> (!i_in_ready && !i_out_valid), "busy side active after reset")

endmodule

bind depth_tested_point_plotter dtpp_checker u_dtpp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_pixel_written   (o_out.pixel_written),
    .i_pixel_index     (o_out.pixel_index),
    .i_shade_index     (o_out.shade_index),
    .i_pixel_intensity (o_out.pixel_intensity)
);

FILE: bench/depth_tested_point_plotter_tb.sv
`timescale 1ns / 1ps

module depth_tested_point_plotter_tb;

    localparam int CLK_HALF_NS = 5;
    localparam int TIMEOUT_NS  = 20_000_000;
    localparam int STORE_SIZE  = dtpp_pkg::MAX_WIDTH_DEF * dtpp_pkg::MAX_HEIGHT_DEF;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic                         written;
        logic [dtpp_pkg::PIX_W-1:0]   pix;
        logic [dtpp_pkg::SHADE_W-1:0] shade;
        logic [dtpp_pkg::INTEN_W-1:0] inten;
    } t_plot_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [dtpp_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [dtpp_pkg::CFG_DATA_W-1:0] i_cfg_data;

    dtpp_in_if  in_if ();
    dtpp_out_if out_if ();

    depth_tested_point_plotter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    int cfg_width;
    int cfg_height;
    int cfg_near;
    int cfg_far;
    int cfg_full;
    logic [dtpp_pkg::INTEN_W-1:0] nearness_map [0:STORE_SIZE-1];

    t_plot_result expected_plots [$];

    int  error_count;
    int  items_sent;
    int  clears_sent;
    int  writes_seen;
    int  drops_seen;
    int  settings_applied;
    int  stall_left;
    bit  no_gaps;

    always begin
        #(CLK_HALF_NS) i_clk = 1'b1;
        #(CLK_HALF_NS) i_clk = 1'b0;
    end

    function automatic t_plot_result predict_plot(
        input logic op,
        input logic signed [dtpp_pkg::COORD_W-1:0] px,
        input logic signed [dtpp_pkg::COORD_W-1:0] py,
        input logic signed [dtpp_pkg::COORD_W-1:0] pz);
        t_plot_result r;
        int x, y, z, w, h, pos, diff, inten, n, idx;
        r = '0;
        if (op == dtpp_pkg::OP_CLEAR) begin
            foreach (nearness_map[k]) nearness_map[k] = '0;
            return r;
        end
        x = int'(px);
        y = int'(py);
        z = int'(pz);
        w = (cfg_width < dtpp_pkg::MAX_WIDTH_DEF) ? cfg_width : dtpp_pkg::MAX_WIDTH_DEF;
        h = (cfg_height < dtpp_pkg::MAX_HEIGHT_DEF) ? cfg_height : dtpp_pkg::MAX_HEIGHT_DEF;
        if (cfg_far == 0) return r;
        if (x < 0 || x >= w || y < 0 || y >= h) return r;
        if (z < cfg_near || z > cfg_far) return r;
        pos = y * w + x;
        if (pos >= STORE_SIZE) return r;
        diff  = cfg_far - z;
        inten = (diff * dtpp_pkg::INTEN_SCALE) / cfg_far;
        if (int'(nearness_map[pos]) > inten) return r;
        n   = cfg_full ? dtpp_pkg::RAMP_LEN_DEF : 2;
        idx = (diff * n) / cfg_far;
        if (idx > n - 1) idx = n - 1;
        if (!cfg_full) idx = (idx != 0) ? dtpp_pkg::RAMP_LEN_DEF - 1 : 0;
        nearness_map[pos] = dtpp_pkg::INTEN_W'(inten);
        r.written = 1'b1;
        r.pix     = dtpp_pkg::PIX_W'(pos);
        r.shade   = dtpp_pkg::SHADE_W'(idx);
        r.inten   = dtpp_pkg::INTEN_W'(inten);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        t_plot_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else if (out_if.valid && out_if.ready) begin
            if (expected_plots.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_plots.pop_front();
                if (out_if.pixel_written !== want.written)
                    report_mismatch("pixel_written", int'(out_if.pixel_written),
                                    int'(want.written));
                if (out_if.pixel_index !== want.pix)
                    report_mismatch("pixel_index", int'(out_if.pixel_index), int'(want.pix));
                if (out_if.shade_index !== want.shade)
                    report_mismatch("shade_index", int'(out_if.shade_index), int'(want.shade));
                if (out_if.pixel_intensity !== want.inten)
                    report_mismatch("pixel_intensity", int'(out_if.pixel_intensity),
                                    int'(want.inten));
                if (want.written) writes_seen++;
                else drops_seen++;
            end
            stall_left = no_gaps ? 0 : $urandom_range(0, 6);
            out_if.ready <= (stall_left == 0);
        end else if (!out_if.ready) begin
            if (stall_left <= 1) begin
                stall_left = 0;
                out_if.ready <= 1'b1;
            end else begin
                stall_left--;
            end
        end
    end

    task automatic send_item(input logic op,
                             input logic signed [dtpp_pkg::COORD_W-1:0] px,
                             input logic signed [dtpp_pkg::COORD_W-1:0] py,
                             input logic signed [dtpp_pkg::COORD_W-1:0] pz);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.operation <= op;
        in_if.point_x   <= px;
        in_if.point_y   <= py;
        in_if.point_z   <= pz;
        expected_plots.push_back(predict_plot(op, px, py, pz));
        items_sent++;
        if (op == dtpp_pkg::OP_CLEAR) clears_sent++;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (expected_plots.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [dtpp_pkg::CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= dtpp_pkg::CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            dtpp_pkg::CFG_SCREEN_WIDTH:   cfg_width  = value & ((1 << dtpp_pkg::SW_W) - 1);
            dtpp_pkg::CFG_SCREEN_HEIGHT:  cfg_height = value & ((1 << dtpp_pkg::SH_W) - 1);
            dtpp_pkg::CFG_NEAR_DEPTH:     cfg_near   = value & ((1 << dtpp_pkg::DEPTH_W) - 1);
            dtpp_pkg::CFG_FAR_DEPTH:      cfg_far    = value & ((1 << dtpp_pkg::DEPTH_W) - 1);
            dtpp_pkg::CFG_FULL_RAMP_MODE: cfg_full   = value & 1;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int w, input int h, input int near_z, input int far_z,
                                 input int full);
        drain_results();
        write_reg(dtpp_pkg::CFG_SCREEN_WIDTH, w);
        write_reg(dtpp_pkg::CFG_SCREEN_HEIGHT, h);
        write_reg(dtpp_pkg::CFG_NEAR_DEPTH, near_z);
        write_reg(dtpp_pkg::CFG_FAR_DEPTH, far_z);
        write_reg(dtpp_pkg::CFG_FULL_RAMP_MODE, full);
        settings_applied++;
    endtask

    task automatic reset_block();
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.operation  = dtpp_pkg::OP_PLOT;
        in_if.point_x    = '0;
        in_if.point_y    = '0;
        in_if.point_z    = '0;
        cfg_width  = 80;
        cfg_height = 40;
        cfg_near   = 1;
        cfg_far    = 100;
        cfg_full   = 1;
        foreach (nearness_map[k]) nearness_map[k] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_screen_and_depth_edges();
        apply_setting(80, 40, 1, 100, 1);
        send_item(dtpp_pkg::OP_PLOT, 0, 0, 1);
        send_item(dtpp_pkg::OP_PLOT, 79, 39, 100);
        send_item(dtpp_pkg::OP_PLOT, -1, 0, 50);
        send_item(dtpp_pkg::OP_PLOT, 80, 0, 50);
        send_item(dtpp_pkg::OP_PLOT, 0, -1, 50);
        send_item(dtpp_pkg::OP_PLOT, 0, 40, 50);
        send_item(dtpp_pkg::OP_PLOT, 3, 3, 0);
        send_item(dtpp_pkg::OP_PLOT, 3, 3, 101);
        send_item(dtpp_pkg::OP_PLOT, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(dtpp_pkg::OP_PLOT, 16'sh8000, 16'sh8000, 16'sh8000);
    endtask

    task automatic test_hidden_and_equal();
        send_item(dtpp_pkg::OP_PLOT, 5, 7, 60);
        send_item(dtpp_pkg::OP_PLOT, 5, 7, 80);
        send_item(dtpp_pkg::OP_PLOT, 5, 7, 60);
        send_item(dtpp_pkg::OP_PLOT, 5, 7, 10);
        send_item(dtpp_pkg::OP_CLEAR, 5, 7, 10);
        send_item(dtpp_pkg::OP_PLOT, 5, 7, 80);
    endtask

    task automatic test_special_settings();
        apply_setting(80, 40, 1, 100, 0);
        send_item(dtpp_pkg::OP_PLOT, 1, 1, 1);
        send_item(dtpp_pkg::OP_PLOT, 1, 2, 90);
        apply_setting(80, 40, 0, 0, 1);
        send_item(dtpp_pkg::OP_PLOT, 2, 2, 0);
        apply_setting(80, 40, 200, 100, 1);
        send_item(dtpp_pkg::OP_PLOT, 2, 2, 150);
        apply_setting(0, 40, 1, 100, 1);
        send_item(dtpp_pkg::OP_PLOT, 0, 0, 50);
        apply_setting(80, 0, 1, 100, 1);
        send_item(dtpp_pkg::OP_PLOT, 0, 0, 50);
        apply_setting(255, 127, 0, 32767, 1);
        send_item(dtpp_pkg::OP_PLOT, 127, 63, 0);
        send_item(dtpp_pkg::OP_PLOT, 128, 0, 5);
        apply_setting(80, 40, 1, 100, 1);
        for (int k = int'(dtpp_pkg::CFG_FULL_RAMP_MODE) + 1; k < (1 << dtpp_pkg::CFG_IDX_W);
             k++)
            write_reg(dtpp_pkg::CFG_IDX_W'(k), (1 << dtpp_pkg::CFG_DATA_W) - 1);
        send_item(dtpp_pkg::OP_PLOT, 4, 4, 30);
    endtask

    task automatic send_random_item();
        int kind, w, h, xi, yi, zi, zlo, zhi;
        kind = $urandom_range(0, 99);
        w = (cfg_width < dtpp_pkg::MAX_WIDTH_DEF) ? cfg_width : dtpp_pkg::MAX_WIDTH_DEF;
        h = (cfg_height < dtpp_pkg::MAX_HEIGHT_DEF) ? cfg_height : dtpp_pkg::MAX_HEIGHT_DEF;
        zlo = cfg_near - 2;
        zhi = (cfg_far + 2 > 32767) ? 32767 : cfg_far + 2;
        if (kind < 2) begin
            send_item(dtpp_pkg::OP_CLEAR, dtpp_pkg::COORD_W'($urandom),
                      dtpp_pkg::COORD_W'($urandom), dtpp_pkg::COORD_W'($urandom));
        end else if (kind < 12) begin
            send_item(dtpp_pkg::OP_PLOT, dtpp_pkg::COORD_W'($urandom),
                      dtpp_pkg::COORD_W'($urandom), dtpp_pkg::COORD_W'($urandom));
        end else if (kind < 45) begin
            xi = $urandom_range(0, (w < 3) ? 0 : 2);
            yi = $urandom_range(0, (h < 2) ? 0 : 1);
            zi = cfg_near + $urandom_range(0, cfg_far - cfg_near);
            send_item(dtpp_pkg::OP_PLOT, dtpp_pkg::COORD_W'(xi), dtpp_pkg::COORD_W'(yi),
                      dtpp_pkg::COORD_W'(zi));
        end else begin
            xi = int'($urandom_range(0, w + 3)) - 2;
            yi = int'($urandom_range(0, h + 3)) - 2;
            zi = int'($urandom_range(0, zhi - zlo)) + zlo;
            send_item(dtpp_pkg::OP_PLOT, dtpp_pkg::COORD_W'(xi), dtpp_pkg::COORD_W'(yi),
                      dtpp_pkg::COORD_W'(zi));
        end
    endtask

    task automatic run_random_phase(input int count, input bit hold_off);
        for (int i = 0; i < count; i++) begin
            if (hold_off && (i % 30 == 29)) drain_results();
            send_random_item();
        end
    endtask

    task automatic test_random_traffic();
        int near_z;
        apply_setting(80, 40, 1, 100, 1);
        run_random_phase(90, 1'b0);
        apply_setting(128, 64, 0, 32767, 1);
        no_gaps = 1'b1;
        run_random_phase(40, 1'b0);
        no_gaps = 1'b0;
        run_random_phase(50, 1'b0);
        apply_setting(7, 3, 50, 60, 0);
        run_random_phase(90, 1'b0);
        apply_setting(128, 64, 32767, 32767, 0);
        run_random_phase(40, 1'b0);
        near_z = $urandom_range(0, 200);
        apply_setting($urandom_range(1, 128), $urandom_range(1, 64), near_z,
                      near_z + $urandom_range(0, 300), $urandom_range(0, 1));
        run_random_phase(110, 1'b1);
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("depth_tested_point_plotter regression: fail");
        $finish;
    end

    initial begin
        error_count      = 0;
        items_sent       = 0;
        clears_sent      = 0;
        writes_seen      = 0;
        drops_seen       = 0;
        settings_applied = 0;
        no_gaps          = 1'b0;
        reset_block();
        test_screen_and_depth_edges();
        test_hidden_and_equal();
        test_special_settings();
        test_random_traffic();
        drain_results();
        repeat (40) @(posedge i_clk);
        if (expected_plots.size() != 0)
            report_mismatch("results still outstanding", 0, expected_plots.size());
        $display("covered %0d transactions (%0d clears): %0d pixel writes, %0d dropped points",
                 items_sent, clears_sent, writes_seen, drops_seen);
        $display("over %0d register settings incl. zero screen, zero far, inverted range",
                 settings_applied);
        if (error_count == 0)
            $display("depth_tested_point_plotter regression: pass");
        else
            $display("depth_tested_point_plotter regression: fail");
        $finish;
    end

endmodule
